// ----- rtl/core/c_tok_pkg.sv -----
// ----------------------------------------------------------------------------
// c_tok_pkg
// Shared types, token kinds and the operator prefix table of the C token
// scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package c_tok_pkg;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [5:0] token_kind;
      logic [7:0] tok_len;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    tok0;
      rsp_type    tok1;
   } rsp_push_type;

   typedef enum logic [5:0] {
      KIND_EOF        = 6'd0,
      KIND_WORD       = 6'd1,
      KIND_LITERAL    = 6'd2,
      KIND_UNKNOWN    = 6'd3,
      KIND_LPAREN     = 6'd4,
      KIND_RPAREN     = 6'd5,
      KIND_LBRACE     = 6'd6,
      KIND_RBRACE     = 6'd7,
      KIND_SEMI       = 6'd8,
      KIND_PLUS       = 6'd9,
      KIND_INC        = 6'd10,
      KIND_PLUS_EQ    = 6'd11,
      KIND_MINUS      = 6'd12,
      KIND_DEC        = 6'd13,
      KIND_MINUS_EQ   = 6'd14,
      KIND_STAR       = 6'd15,
      KIND_STAR_EQ    = 6'd16,
      KIND_SLASH      = 6'd17,
      KIND_SLASH_EQ   = 6'd18,
      KIND_PERCENT    = 6'd19,
      KIND_PERCENT_EQ = 6'd20,
      KIND_AMP        = 6'd21,
      KIND_AND_AND    = 6'd22,
      KIND_AMP_EQ     = 6'd23,
      KIND_BAR        = 6'd24,
      KIND_OR_OR      = 6'd25,
      KIND_BAR_EQ     = 6'd26,
      KIND_CARET      = 6'd27,
      KIND_CARET_EQ   = 6'd28,
      KIND_BANG       = 6'd29,
      KIND_NOT_EQ     = 6'd30,
      KIND_ASSIGN     = 6'd31,
      KIND_EQ_EQ      = 6'd32,
      KIND_LT         = 6'd33,
      KIND_SHL        = 6'd34,
      KIND_SHL_EQ     = 6'd35,
      KIND_LT_EQ      = 6'd36,
      KIND_GT         = 6'd37,
      KIND_SHR        = 6'd38,
      KIND_SHR_EQ     = 6'd39,
      KIND_GT_EQ      = 6'd40,
      KIND_TILDE      = 6'd41,
      KIND_QUESTION   = 6'd42,
      KIND_COLON      = 6'd43
   } kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_WORD = 4'b0010,
      MODE_NUM  = 4'b0100,
      MODE_OP   = 4'b1000
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic [3:0] op_idx;
      logic [7:0] run_len;
      logic       skip;
   } scan_state_type;

   localparam logic [3:0] OP_PLUS    = 4'd0;
   localparam logic [3:0] OP_MINUS   = 4'd1;
   localparam logic [3:0] OP_STAR    = 4'd2;
   localparam logic [3:0] OP_SLASH   = 4'd3;
   localparam logic [3:0] OP_PERCENT = 4'd4;
   localparam logic [3:0] OP_AMP     = 4'd5;
   localparam logic [3:0] OP_BAR     = 4'd6;
   localparam logic [3:0] OP_CARET   = 4'd7;
   localparam logic [3:0] OP_BANG    = 4'd8;
   localparam logic [3:0] OP_ASSIGN  = 4'd9;
   localparam logic [3:0] OP_LT      = 4'd10;
   localparam logic [3:0] OP_SHL     = 4'd11;
   localparam logic [3:0] OP_GT      = 4'd12;
   localparam logic [3:0] OP_SHR     = 4'd13;

   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_PERCENT    = 8'h25;
   localparam logic [7:0] CH_AMP        = 8'h26;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_COLON      = 8'h3A;
   localparam logic [7:0] CH_SEMI       = 8'h3B;
   localparam logic [7:0] CH_LT         = 8'h3C;
   localparam logic [7:0] CH_EQ         = 8'h3D;
   localparam logic [7:0] CH_GT         = 8'h3E;
   localparam logic [7:0] CH_QUESTION   = 8'h3F;
   localparam logic [7:0] CH_CARET      = 8'h5E;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LBRACE     = 8'h7B;
   localparam logic [7:0] CH_BAR        = 8'h7C;
   localparam logic [7:0] CH_RBRACE     = 8'h7D;
   localparam logic [7:0] CH_TILDE      = 8'h7E;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] len;
      logic       k1_vld;
      logic [7:0] c1;
      kind_type   k1;
      logic       g1_vld;
      logic [3:0] g1;
      logic       k2_vld;
      logic [7:0] c2;
      kind_type   k2;
   } op_entry_type;

   function automatic op_entry_type op_entry_get(input logic [3:0] idx);
      op_entry_type e;
      e.kind   = KIND_UNKNOWN;
      e.len    = 2'd1;
      e.k1_vld = 1'b0;
      e.c1     = CH_EQ;
      e.k1     = KIND_UNKNOWN;
      e.g1_vld = 1'b0;
      e.g1     = OP_PLUS;
      e.k2_vld = 1'b0;
      e.c2     = CH_EQ;
      e.k2     = KIND_UNKNOWN;
      case (idx)
         OP_PLUS: begin
            e.kind = KIND_PLUS;  e.k1_vld = 1'b1; e.c1 = CH_PLUS;  e.k1 = KIND_INC;
            e.k2_vld = 1'b1; e.k2 = KIND_PLUS_EQ;
         end
         OP_MINUS: begin
            e.kind = KIND_MINUS; e.k1_vld = 1'b1; e.c1 = CH_MINUS; e.k1 = KIND_DEC;
            e.k2_vld = 1'b1; e.k2 = KIND_MINUS_EQ;
         end
         OP_STAR: begin
            e.kind = KIND_STAR; e.k1_vld = 1'b1; e.k1 = KIND_STAR_EQ;
         end
         OP_SLASH: begin
            e.kind = KIND_SLASH; e.k1_vld = 1'b1; e.k1 = KIND_SLASH_EQ;
         end
         OP_PERCENT: begin
            e.kind = KIND_PERCENT; e.k1_vld = 1'b1; e.k1 = KIND_PERCENT_EQ;
         end
         OP_AMP: begin
            e.kind = KIND_AMP; e.k1_vld = 1'b1; e.c1 = CH_AMP; e.k1 = KIND_AND_AND;
            e.k2_vld = 1'b1; e.k2 = KIND_AMP_EQ;
         end
         OP_BAR: begin
            e.kind = KIND_BAR; e.k1_vld = 1'b1; e.c1 = CH_BAR; e.k1 = KIND_OR_OR;
            e.k2_vld = 1'b1; e.k2 = KIND_BAR_EQ;
         end
         OP_CARET: begin
            e.kind = KIND_CARET; e.k1_vld = 1'b1; e.k1 = KIND_CARET_EQ;
         end
         OP_BANG: begin
            e.kind = KIND_BANG; e.k1_vld = 1'b1; e.k1 = KIND_NOT_EQ;
         end
         OP_ASSIGN: begin
            e.kind = KIND_ASSIGN; e.k1_vld = 1'b1; e.k1 = KIND_EQ_EQ;
         end
         OP_LT: begin
            e.kind = KIND_LT; e.k1_vld = 1'b1; e.c1 = CH_LT; e.k1 = KIND_SHL;
            e.g1_vld = 1'b1; e.g1 = OP_SHL;
            e.k2_vld = 1'b1; e.k2 = KIND_LT_EQ;
         end
         OP_SHL: begin
            e.kind = KIND_SHL; e.len = 2'd2; e.k1_vld = 1'b1; e.k1 = KIND_SHL_EQ;
         end
         OP_GT: begin
            e.kind = KIND_GT; e.k1_vld = 1'b1; e.c1 = CH_GT; e.k1 = KIND_SHR;
            e.g1_vld = 1'b1; e.g1 = OP_SHR;
            e.k2_vld = 1'b1; e.k2 = KIND_GT_EQ;
         end
         OP_SHR: begin
            e.kind = KIND_SHR; e.len = 2'd2; e.k1_vld = 1'b1; e.k1 = KIND_SHR_EQ;
         end
         default: begin
            e.kind = KIND_UNKNOWN;
         end
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/c_tok_step.sv -----
// ----------------------------------------------------------------------------
// c_tok_step
// Combinational scan step: from the current scan state and one input byte,
// forms up to two tokens and the next scan state.
// ----------------------------------------------------------------------------
`default_nettype none

module c_tok_step #(
   parameter int unsigned MAX_TOKEN_LEN = 255
) (
   input  c_tok_pkg::scan_state_type state,
   input  c_tok_pkg::req_type        item,
   output c_tok_pkg::scan_state_type next_state,
   output c_tok_pkg::rsp_push_type   push
);

   localparam logic [7:0] LenLimit = (MAX_TOKEN_LEN < 255) ? 8'(MAX_TOKEN_LEN) : 8'd255;

   logic [7:0] c;
   logic       is_alpha;
   logic       is_digit;
   logic       is_space;
   logic       is_eol;

   c_tok_pkg::op_entry_type ent;

   logic                 st_emit;
   c_tok_pkg::kind_type  st_kind;
   c_tok_pkg::mode_type  st_mode;
   logic [3:0]           st_op;
   logic [7:0]           st_run;
   logic                 st_skip;

   logic                 fl_emit;
   c_tok_pkg::kind_type  fl_kind;
   logic [7:0]           fl_len;

   logic                 a_vld;
   c_tok_pkg::kind_type  a_kind;
   logic [7:0]           a_len;
   logic                 b_vld;
   c_tok_pkg::kind_type  b_kind;
   logic [7:0]           b_len;
   logic                 use_start;
   logic [7:0]           run_grown;

   assign c        = item.ch;
   assign is_alpha = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
   assign is_digit = (c inside {[8'h30:8'h39]});
   assign is_space = (c inside {8'h20, [8'h09:8'h0D]});
   assign is_eol   = (c == c_tok_pkg::CH_LF) || (c == c_tok_pkg::CH_CR);
   assign ent      = c_tok_pkg::op_entry_get(state.op_idx);
   assign run_grown = (state.run_len < LenLimit) ? state.run_len + 8'd1 : state.run_len;

   always_comb begin
      st_emit = 1'b0;
      st_kind = c_tok_pkg::KIND_UNKNOWN;
      st_mode = c_tok_pkg::MODE_IDLE;
      st_op   = c_tok_pkg::OP_PLUS;
      st_run  = 8'd0;
      st_skip = 1'b0;
      if (c == c_tok_pkg::CH_NUL) begin
         st_skip = 1'b1;
      end else if (is_space) begin
         st_mode = c_tok_pkg::MODE_IDLE;
      end else if (is_alpha || (c == c_tok_pkg::CH_UNDERSCORE)) begin
         st_mode = c_tok_pkg::MODE_WORD;
         st_run  = 8'd1;
      end else if (is_digit) begin
         st_mode = c_tok_pkg::MODE_NUM;
         st_run  = 8'd1;
      end else begin
         case (c)
            c_tok_pkg::CH_LPAREN: begin st_emit = 1'b1; st_kind = c_tok_pkg::KIND_LPAREN; end
            c_tok_pkg::CH_RPAREN: begin st_emit = 1'b1; st_kind = c_tok_pkg::KIND_RPAREN; end
            c_tok_pkg::CH_LBRACE: begin st_emit = 1'b1; st_kind = c_tok_pkg::KIND_LBRACE; end
            c_tok_pkg::CH_RBRACE: begin st_emit = 1'b1; st_kind = c_tok_pkg::KIND_RBRACE; end
            c_tok_pkg::CH_SEMI: begin st_emit = 1'b1; st_kind = c_tok_pkg::KIND_SEMI; end
            c_tok_pkg::CH_TILDE: begin st_emit = 1'b1; st_kind = c_tok_pkg::KIND_TILDE; end
            c_tok_pkg::CH_QUESTION: begin
               st_emit = 1'b1;
               st_kind = c_tok_pkg::KIND_QUESTION;
            end
            c_tok_pkg::CH_COLON: begin st_emit = 1'b1; st_kind = c_tok_pkg::KIND_COLON; end
            c_tok_pkg::CH_PLUS: begin st_mode = c_tok_pkg::MODE_OP; st_op = c_tok_pkg::OP_PLUS; end
            c_tok_pkg::CH_MINUS: begin
               st_mode = c_tok_pkg::MODE_OP;
               st_op   = c_tok_pkg::OP_MINUS;
            end
            c_tok_pkg::CH_STAR: begin st_mode = c_tok_pkg::MODE_OP; st_op = c_tok_pkg::OP_STAR; end
            c_tok_pkg::CH_SLASH: begin
               st_mode = c_tok_pkg::MODE_OP;
               st_op   = c_tok_pkg::OP_SLASH;
            end
            c_tok_pkg::CH_PERCENT: begin
               st_mode = c_tok_pkg::MODE_OP;
               st_op   = c_tok_pkg::OP_PERCENT;
            end
            c_tok_pkg::CH_AMP: begin st_mode = c_tok_pkg::MODE_OP; st_op = c_tok_pkg::OP_AMP; end
            c_tok_pkg::CH_BAR: begin st_mode = c_tok_pkg::MODE_OP; st_op = c_tok_pkg::OP_BAR; end
            c_tok_pkg::CH_CARET: begin
               st_mode = c_tok_pkg::MODE_OP;
               st_op   = c_tok_pkg::OP_CARET;
            end
            c_tok_pkg::CH_BANG: begin st_mode = c_tok_pkg::MODE_OP; st_op = c_tok_pkg::OP_BANG; end
            c_tok_pkg::CH_EQ: begin st_mode = c_tok_pkg::MODE_OP; st_op = c_tok_pkg::OP_ASSIGN; end
            c_tok_pkg::CH_LT: begin st_mode = c_tok_pkg::MODE_OP; st_op = c_tok_pkg::OP_LT; end
            c_tok_pkg::CH_GT: begin st_mode = c_tok_pkg::MODE_OP; st_op = c_tok_pkg::OP_GT; end
            default: begin
               st_emit = 1'b1;
               st_kind = c_tok_pkg::KIND_UNKNOWN;
            end
         endcase
      end
   end

   always_comb begin
      fl_emit = 1'b0;
      fl_kind = c_tok_pkg::KIND_EOF;
      fl_len  = 8'd0;
      case (state.mode)
         c_tok_pkg::MODE_WORD: begin
            fl_emit = 1'b1;
            fl_kind = c_tok_pkg::KIND_WORD;
            fl_len  = state.run_len;
         end
         c_tok_pkg::MODE_NUM: begin
            fl_emit = 1'b1;
            fl_kind = c_tok_pkg::KIND_LITERAL;
            fl_len  = state.run_len;
         end
         c_tok_pkg::MODE_OP: begin
            fl_emit = 1'b1;
            fl_kind = ent.kind;
            fl_len  = {6'd0, ent.len};
         end
         default: begin
            fl_emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      a_vld      = 1'b0;
      a_kind     = c_tok_pkg::KIND_EOF;
      a_len      = 8'd0;
      b_vld      = 1'b0;
      b_kind     = c_tok_pkg::KIND_EOF;
      b_len      = 8'd0;
      use_start  = 1'b0;
      next_state = state;
      if (item.end_of_input) begin
         a_vld              = fl_emit;
         a_kind             = fl_kind;
         a_len              = fl_len;
         b_vld              = 1'b1;
         next_state.mode    = c_tok_pkg::MODE_IDLE;
         next_state.op_idx  = c_tok_pkg::OP_PLUS;
         next_state.run_len = 8'd0;
         next_state.skip    = 1'b0;
      end else if (state.skip) begin
         if (is_eol) begin
            next_state.skip = 1'b0;
         end
      end else begin
         case (state.mode)
            c_tok_pkg::MODE_WORD: begin
               if (is_alpha || is_digit || (c == c_tok_pkg::CH_UNDERSCORE)) begin
                  next_state.run_len = run_grown;
               end else begin
                  a_vld     = fl_emit;
                  a_kind    = fl_kind;
                  a_len     = fl_len;
                  use_start = 1'b1;
               end
            end
            c_tok_pkg::MODE_NUM: begin
               if (is_digit) begin
                  next_state.run_len = run_grown;
               end else if (is_alpha || (c == c_tok_pkg::CH_UNDERSCORE)) begin
                  a_vld     = 1'b1;
                  a_kind    = c_tok_pkg::KIND_UNKNOWN;
                  a_len     = state.run_len;
                  use_start = 1'b1;
               end else begin
                  a_vld     = fl_emit;
                  a_kind    = fl_kind;
                  a_len     = fl_len;
                  use_start = 1'b1;
               end
            end
            c_tok_pkg::MODE_OP: begin
               if (ent.k1_vld && (c == ent.c1)) begin
                  if (ent.g1_vld) begin
                     next_state.op_idx = ent.g1;
                  end else begin
                     a_vld           = 1'b1;
                     a_kind          = ent.k1;
                     a_len           = {6'd0, ent.len} + 8'd1;
                     next_state.mode = c_tok_pkg::MODE_IDLE;
                  end
               end else if (ent.k2_vld && (c == ent.c2)) begin
                  a_vld           = 1'b1;
                  a_kind          = ent.k2;
                  a_len           = {6'd0, ent.len} + 8'd1;
                  next_state.mode = c_tok_pkg::MODE_IDLE;
               end else begin
                  a_vld     = fl_emit;
                  a_kind    = fl_kind;
                  a_len     = fl_len;
                  use_start = 1'b1;
               end
            end
            default: begin
               use_start = 1'b1;
            end
         endcase
         if (use_start) begin
            b_vld              = st_emit;
            b_kind             = st_kind;
            b_len              = 8'd1;
            next_state.mode    = st_mode;
            next_state.op_idx  = st_op;
            next_state.run_len = st_run;
            next_state.skip    = st_skip;
         end
      end
   end

   always_comb begin
      push.cnt = {1'b0, a_vld} + {1'b0, b_vld};
      push.tok1.token_kind = b_kind;
      push.tok1.tok_len    = b_len;
      push.tok1.last       = 1'b1;
      if (a_vld) begin
         push.tok0.token_kind = a_kind;
         push.tok0.tok_len    = a_len;
         push.tok0.last       = !b_vld;
      end else begin
         push.tok0 = push.tok1;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/c_tok_rsp_buf.sv -----
// ----------------------------------------------------------------------------
// c_tok_rsp_buf
// Two-entry result buffer. Takes up to two tokens at once and hands them out
// one transaction at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module c_tok_rsp_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  c_tok_pkg::rsp_push_type push,
   output logic [1:0]              free_cnt,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output c_tok_pkg::rsp_type      rsp_data
);

   logic [1:0]         cnt_ff;
   logic [1:0]         cnt_in;
   c_tok_pkg::rsp_type slot0_ff;
   c_tok_pkg::rsp_type slot0_in;
   c_tok_pkg::rsp_type slot1_ff;
   c_tok_pkg::rsp_type slot1_in;

   logic               pop;
   logic [1:0]         cnt_after;
   c_tok_pkg::rsp_type head_after;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign free_cnt  = 2'd2 - cnt_ff;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      cnt_after  = pop ? cnt_ff - 2'd1 : cnt_ff;
      head_after = pop ? slot1_ff : slot0_ff;
      slot0_in   = head_after;
      slot1_in   = slot1_ff;
      case (cnt_after)
         2'd0: begin
            slot0_in = push.tok0;
            slot1_in = push.tok1;
         end
         2'd1: begin
            slot1_in = push.tok0;
         end
         default: begin
            slot1_in = slot1_ff;
         end
      endcase
      cnt_in = cnt_after + push.cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/c_token_scanner_core.sv -----
// ----------------------------------------------------------------------------
// c_token_scanner_core
// Streaming longest-match C tokenizer: one source byte in, up to two tokens
// out per byte.
//
//   Port group | Direction | Carries
//   req_       | in        | one source byte or the end marker
//   rsp_       | out       | one token: kind, length, last flag
//
// A byte is registered on acceptance and scanned once the result buffer has
// room for its tokens, which then enter that two-entry buffer. One byte per
// cycle is sustained while each byte yields at most one token and the output
// is ready; a byte with two tokens waits for an empty result buffer and can
// stall the input even with the output always ready.
// The scan step waits only for room in the result buffer.
// Synchronous reset returns the scanner to idle with no pending token.
// ----------------------------------------------------------------------------
`default_nettype none

module c_token_scanner_core #(
   parameter int unsigned MAX_TOKEN_LEN = 255
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  c_tok_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output c_tok_pkg::rsp_type rsp_data
);

   logic                      in_vld_ff;
   logic                      in_vld_in;
   c_tok_pkg::req_type        in_data_ff;
   c_tok_pkg::scan_state_type state_ff;
   c_tok_pkg::scan_state_type state_in;

   c_tok_pkg::scan_state_type step_state;
   c_tok_pkg::rsp_push_type   step_push;
   c_tok_pkg::rsp_push_type   buf_push;
   logic [1:0]                free_cnt;
   logic                      fire;
   logic                      req_accept;

   c_tok_step #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
   ) u_step (
      .state      (state_ff),
      .item       (in_data_ff),
      .next_state (step_state),
      .push       (step_push)
   );

   assign fire       = in_vld_ff && (step_push.cnt <= free_cnt);
   assign req_ready  = !in_vld_ff || fire;
   assign req_accept = req_valid && req_ready;
   assign in_vld_in  = req_accept || (in_vld_ff && !fire);
   assign state_in   = fire ? step_state : state_ff;

   always_comb begin
      buf_push     = step_push;
      buf_push.cnt = fire ? step_push.cnt : 2'd0;
   end

   c_tok_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (buf_push),
      .free_cnt  (free_cnt),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff        <= 1'b0;
         state_ff.mode    <= c_tok_pkg::MODE_IDLE;
         state_ff.op_idx  <= c_tok_pkg::OP_PLUS;
         state_ff.run_len <= 8'd0;
         state_ff.skip    <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         state_ff  <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

// ----- tb/c_token_scanner_checker.sv -----
// ----------------------------------------------------------------------------
// c_token_scanner_checker
// Watches both channels of the C token scanner. Every accepted source byte
// is run through a local longest-match scanner that predicts the tokens it
// completes, and every accepted token is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module c_token_scanner_checker
   import c_tok_pkg::*;
#(
   parameter int unsigned MAX_TOKEN_LEN = 255
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] LEN_CAP  = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN[7:0] : 8'd255;

   typedef struct packed {
      kind_type   alone;
      logic [1:0] plen;
      logic       has1;
      logic [7:0] ext1;
      kind_type   kind1;
      logic       grows;
      logic [3:0] grow_to;
      logic       has2;
      logic [7:0] ext2;
      kind_type   kind2;
   } prefix_rule;

   mode_type   scan_state;
   logic [3:0] prefix_idx;
   logic [7:0] word_len;
   logic       dropping_line;
   rsp_type    step_tokens[$];
   rsp_type    pending_tokens[$];

   function automatic prefix_rule rule_of(input logic [3:0] idx);
      prefix_rule r;
      r = '0;
      r.plen = 2'd1;
      r.has1 = 1'b1;
      r.ext1 = CH_EQ;
      r.ext2 = CH_EQ;
      case (idx)
         OP_PLUS: begin
            r.alone = KIND_PLUS; r.ext1 = CH_PLUS; r.kind1 = KIND_INC;
            r.has2 = 1'b1; r.kind2 = KIND_PLUS_EQ;
         end
         OP_MINUS: begin
            r.alone = KIND_MINUS; r.ext1 = CH_MINUS; r.kind1 = KIND_DEC;
            r.has2 = 1'b1; r.kind2 = KIND_MINUS_EQ;
         end
         OP_STAR:    begin r.alone = KIND_STAR;    r.kind1 = KIND_STAR_EQ;    end
         OP_SLASH:   begin r.alone = KIND_SLASH;   r.kind1 = KIND_SLASH_EQ;   end
         OP_PERCENT: begin r.alone = KIND_PERCENT; r.kind1 = KIND_PERCENT_EQ; end
         OP_AMP: begin
            r.alone = KIND_AMP; r.ext1 = CH_AMP; r.kind1 = KIND_AND_AND;
            r.has2 = 1'b1; r.kind2 = KIND_AMP_EQ;
         end
         OP_BAR: begin
            r.alone = KIND_BAR; r.ext1 = CH_BAR; r.kind1 = KIND_OR_OR;
            r.has2 = 1'b1; r.kind2 = KIND_BAR_EQ;
         end
         OP_CARET:  begin r.alone = KIND_CARET;  r.kind1 = KIND_CARET_EQ; end
         OP_BANG:   begin r.alone = KIND_BANG;   r.kind1 = KIND_NOT_EQ;   end
         OP_ASSIGN: begin r.alone = KIND_ASSIGN; r.kind1 = KIND_EQ_EQ;    end
         OP_LT: begin
            r.alone = KIND_LT; r.ext1 = CH_LT; r.kind1 = KIND_SHL;
            r.grows = 1'b1; r.grow_to = OP_SHL;
            r.has2 = 1'b1; r.kind2 = KIND_LT_EQ;
         end
         OP_SHL: begin r.alone = KIND_SHL; r.plen = 2'd2; r.kind1 = KIND_SHL_EQ; end
         OP_GT: begin
            r.alone = KIND_GT; r.ext1 = CH_GT; r.kind1 = KIND_SHR;
            r.grows = 1'b1; r.grow_to = OP_SHR;
            r.has2 = 1'b1; r.kind2 = KIND_GT_EQ;
         end
         default: begin r.alone = KIND_SHR; r.plen = 2'd2; r.kind1 = KIND_SHR_EQ; end
      endcase
      return r;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   task automatic add_token(input kind_type k, input logic [7:0] n);
      rsp_type t;
      t.token_kind = k;
      t.tok_len    = n;
      t.last       = 1'b0;
      if (step_tokens.size() < 2) step_tokens.push_back(t);
   endtask

   task automatic close_pending();
      prefix_rule r;
      r = rule_of(prefix_idx);
      case (scan_state)
         MODE_WORD: add_token(KIND_WORD, word_len);
         MODE_NUM:  add_token(KIND_LITERAL, word_len);
         MODE_OP:   add_token(r.alone, {6'd0, r.plen});
         default: ;
      endcase
      scan_state = MODE_IDLE;
      word_len   = 8'd0;
   endtask

   task automatic open_token(input logic [7:0] c);
      scan_state = MODE_IDLE;
      word_len   = 8'd0;
      if (c == CH_NUL) begin
         dropping_line = 1'b1;
      end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
         scan_state = MODE_WORD;
         word_len   = 8'd1;
      end else if (is_digit(c)) begin
         scan_state = MODE_NUM;
         word_len   = 8'd1;
      end else begin
         scan_state = MODE_OP;
         case (c)
            CH_LPAREN:   begin scan_state = MODE_IDLE; add_token(KIND_LPAREN, 8'd1);   end
            CH_RPAREN:   begin scan_state = MODE_IDLE; add_token(KIND_RPAREN, 8'd1);   end
            CH_LBRACE:   begin scan_state = MODE_IDLE; add_token(KIND_LBRACE, 8'd1);   end
            CH_RBRACE:   begin scan_state = MODE_IDLE; add_token(KIND_RBRACE, 8'd1);   end
            CH_SEMI:     begin scan_state = MODE_IDLE; add_token(KIND_SEMI, 8'd1);     end
            CH_TILDE:    begin scan_state = MODE_IDLE; add_token(KIND_TILDE, 8'd1);    end
            CH_QUESTION: begin scan_state = MODE_IDLE; add_token(KIND_QUESTION, 8'd1); end
            CH_COLON:    begin scan_state = MODE_IDLE; add_token(KIND_COLON, 8'd1);    end
            CH_PLUS:     prefix_idx = OP_PLUS;
            CH_MINUS:    prefix_idx = OP_MINUS;
            CH_STAR:     prefix_idx = OP_STAR;
            CH_SLASH:    prefix_idx = OP_SLASH;
            CH_PERCENT:  prefix_idx = OP_PERCENT;
            CH_AMP:      prefix_idx = OP_AMP;
            CH_BAR:      prefix_idx = OP_BAR;
            CH_CARET:    prefix_idx = OP_CARET;
            CH_BANG:     prefix_idx = OP_BANG;
            CH_EQ:       prefix_idx = OP_ASSIGN;
            CH_LT:       prefix_idx = OP_LT;
            CH_GT:       prefix_idx = OP_GT;
            default:     begin scan_state = MODE_IDLE; add_token(KIND_UNKNOWN, 8'd1); end
         endcase
      end
   endtask

   task automatic scan_byte(input req_type item);
      logic [7:0] c;
      prefix_rule r;
      c = item.ch;
      r = rule_of(prefix_idx);
      step_tokens = {};
      if (item.end_of_input) begin
         close_pending();
         add_token(KIND_EOF, 8'd0);
         dropping_line = 1'b0;
      end else if (dropping_line) begin
         if (c == CH_LF || c == CH_CR) dropping_line = 1'b0;
      end else begin
         case (scan_state)
            MODE_WORD: begin
               if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE) begin
                  if (word_len < LEN_CAP) word_len++;
               end else begin
                  close_pending();
                  open_token(c);
               end
            end
            MODE_NUM: begin
               if (is_digit(c)) begin
                  if (word_len < LEN_CAP) word_len++;
               end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
                  add_token(KIND_UNKNOWN, word_len);
                  open_token(c);
               end else begin
                  close_pending();
                  open_token(c);
               end
            end
            MODE_OP: begin
               if (r.has1 && c == r.ext1) begin
                  if (r.grows) begin
                     prefix_idx = r.grow_to;
                  end else begin
                     add_token(r.kind1, {6'd0, r.plen} + 8'd1);
                     scan_state = MODE_IDLE;
                  end
               end else if (r.has2 && c == r.ext2) begin
                  add_token(r.kind2, {6'd0, r.plen} + 8'd1);
                  scan_state = MODE_IDLE;
               end else begin
                  close_pending();
                  open_token(c);
               end
            end
            default: open_token(c);
         endcase
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
   endtask

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         scan_state     = MODE_IDLE;
         prefix_idx     = OP_PLUS;
         word_len       = 8'd0;
         dropping_line  = 1'b0;
         pending_tokens = {};
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_tokens.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected transaction: kind %0d length %0d last %0b",
                           rsp_data.token_kind, rsp_data.tok_len, rsp_data.last);
            end else begin
               want = pending_tokens.pop_front();
               if (rsp_data.token_kind !== want.token_kind ||
                   rsp_data.tok_len !== want.tok_len ||
                   rsp_data.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"Token mismatch: expected kind %0d length %0d last %0b, ",
                               "got kind %0d length %0d last %0b"},
                              want.token_kind, want.tok_len, want.last,
                              rsp_data.token_kind, rsp_data.tok_len, rsp_data.last);
               end
            end
         end
         if (req_valid && req_ready) scan_byte(req_data);
      end
      outstanding = pending_tokens.size();
   end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives the C token scanner with a short directed text and then with random
// source made mostly of well-formed words, literals, operators, blanks and line
// breaks, mixed with stray bytes, dropped lines and end markers. Both
// channels stall at random; the checker beside the block reports the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import c_tok_pkg::*;

   localparam int unsigned TOKEN_CAP = 255;
   localparam logic [7:0]  CH_SPACE  = 8'h20;
   localparam logic [7:0]  CH_TAB    = 8'h09;
   localparam logic [7:0]  CH_VT     = 8'h0B;
   localparam logic [7:0]  CH_FF     = 8'h0C;
   localparam int          RANDOM_BYTES = 1850;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    req_fire = 1'b0;
   logic    calm = 1'b0;
   int      mismatches;
   int      outstanding;
   int      bytes_sent = 0;

   string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string op_spell [0:39] = '{"(", ")", "{", "}", ";", "+", "++", "+=", "-", "--", "-=",
                              "*", "*=", "/", "/=", "%", "%=", "&", "&&", "&=", "|", "||",
                              "|=", "^", "^=", "!", "!=", "=", "==", "<", "<<", "<<=", "<=",
                              ">", ">>", ">>=", ">=", "~", "?", ":"};

   c_token_scanner_core #(
      .MAX_TOKEN_LEN(TOKEN_CAP)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   c_token_scanner_checker #(
      .MAX_TOKEN_LEN(TOKEN_CAP)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) req_fire <= req_valid && req_ready;

   always @(negedge clock) rsp_ready <= calm || ($urandom_range(99) >= 34);

   task automatic push_byte(input logic [7:0] c, input logic eoi);
      req_type item;
      item.ch           = c;
      item.end_of_input = eoi;
      while (!calm && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(negedge clock); while (!req_fire);
      bytes_sent++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
   endtask

   function automatic logic [7:0] word_char(input logic lead);
      return word_chars[$urandom_range(lead ? 52 : 62, 0)];
   endfunction

   initial begin : stimulus
      int  sel;
      int  n;
      logic drained;
      drained = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Word, digit run into a word, three-character operators, top byte, dropped
      // line ended by CR LF, doubled ampersand and two end markers, each after an open token.
      push_text("_z9<<=>>=12a");
      push_byte(8'hFF, 1'b0);
      push_byte(CH_NUL, 1'b0);
      push_text("q");
      push_byte(CH_CR, 1'b0);
      push_byte(CH_LF, 1'b0);
      push_text("&&|");
      push_byte(8'hFF, 1'b1);
      push_text("x>");
      push_byte(CH_NUL, 1'b1);

      n = bytes_sent;
      while (bytes_sent < n + RANDOM_BYTES) begin
         calm = (bytes_sent > n + 700) && (bytes_sent < n + 1000);
         if (!drained && bytes_sent > n + 1300) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            @(negedge clock);
            while (outstanding != 0) @(negedge clock);
         end
         sel = $urandom_range(99);
         if (sel < 28) begin
            push_byte(word_char(1'b1), 1'b0);
            repeat (($urandom_range(99) == 0) ? $urandom_range(300, 250) : $urandom_range(7, 0))
               push_byte(word_char(1'b0), 1'b0);
         end else if (sel < 46) begin
            repeat (($urandom_range(199) == 0) ? $urandom_range(280, 256) : $urandom_range(5, 1))
               push_byte(word_chars[$urandom_range(62, 53)], 1'b0);
            if ($urandom_range(3) == 0) push_byte(word_char(1'b1), 1'b0);
         end else if (sel < 78) begin
            push_text(op_spell[$urandom_range(39)]);
         end else if (sel < 88) begin
            case ($urandom_range(5))
               0: push_byte(CH_SPACE, 1'b0);
               1: push_byte(CH_TAB, 1'b0);
               2: push_byte(CH_LF, 1'b0);
               3: push_byte(CH_CR, 1'b0);
               4: begin push_byte(CH_CR, 1'b0); push_byte(CH_LF, 1'b0); end
               default: push_byte($urandom_range(1) ? CH_VT : CH_FF, 1'b0);
            endcase
         end else if (sel < 93) begin
            push_byte(8'($urandom_range(255)), 1'b0);
         end else if (sel < 97) begin
            push_byte(CH_NUL, 1'b0);
            repeat ($urandom_range(5)) push_byte(8'($urandom_range(255)), 1'b0);
            case ($urandom_range(2))
               0: push_byte(CH_LF, 1'b0);
               1: push_byte(CH_CR, 1'b0);
               default: begin push_byte(CH_CR, 1'b0); push_byte(CH_LF, 1'b0); end
            endcase
         end else begin
            push_byte(8'($urandom_range(255)), 1'b1);
         end
      end
      calm = 1'b0;
      push_byte(8'($urandom_range(255)), 1'b1);
      req_valid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
